// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the formatter (ssf_checker).
// No dependencies; clock and reset are named clk_i and rst_ni at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, out of reset.
`define SSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in one cycle brings another in the next cycle.
`define SSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ssf_pkg.sv =====
// Package of the seven-segment tenths formatter: constants, result type, segment map.
// No dependencies.
`default_nettype none

package ssf_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned MagWidth   = 14;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned DigitWidth = 4;

  localparam logic [14:0] MaxShown = 15'd9999;
  localparam logic [7:0]  SegDp    = 8'h10;
  localparam logic [7:0]  SegBlank = 8'h00;

  // Reciprocals for division by constants, exact for every value up to MaxShown.
  localparam logic [15:0] RecipTen      = 16'd52429;  // 2^19 / 10, rounded up
  localparam logic [12:0] RecipHundred  = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [14:0] RecipThousand = 15'd16778;  // 2^24 / 1000, rounded up

  typedef struct packed {
    logic                row_out;
    logic [SegWidth-1:0] digit_ones;
    logic [SegWidth-1:0] digit_tens;
    logic [SegWidth-1:0] digit_hundreds;
    logic [SegWidth-1:0] digit_thousands;
    logic                updated;
  } ssf_result_t;

  function automatic logic [SegWidth-1:0] seg_encode(input logic [DigitWidth-1:0] digit);
    logic [SegWidth-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hED;
      4'd1:    seg = 8'h21;
      4'd2:    seg = 8'h8F;
      4'd3:    seg = 8'hAB;
      4'd4:    seg = 8'h63;
      4'd5:    seg = 8'hEA;
      4'd6:    seg = 8'hEE;
      4'd7:    seg = 8'hA1;
      4'd8:    seg = 8'hEF;
      4'd9:    seg = 8'hEB;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ssf_in_if.sv =====
// Input channel of the formatter: valid/ready handshake with a reading and a row select.
// Depends on ssf_pkg for field widths.
`default_nettype none

interface ssf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ssf_pkg::ValueWidth-1:0] value;
  logic                                  row;

  modport source (output valid, output value, output row, input ready);
  modport sink   (input valid, input value, input row, output ready);
endinterface

`default_nettype wire

// ===== sv/ssf_out_if.sv =====
// Output channel of the formatter: valid/ready handshake with four segment bytes.
// Depends on ssf_pkg for field widths.
`default_nettype none

interface ssf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         row_out;
  logic [ssf_pkg::SegWidth-1:0] digit_ones;
  logic [ssf_pkg::SegWidth-1:0] digit_tens;
  logic [ssf_pkg::SegWidth-1:0] digit_hundreds;
  logic [ssf_pkg::SegWidth-1:0] digit_thousands;
  logic                         updated;

  modport source (output valid, output row_out, output digit_ones, output digit_tens,
                  output digit_hundreds, output digit_thousands, output updated,
                  input ready);
  modport sink   (input valid, input row_out, input digit_ones, input digit_tens,
                  input digit_hundreds, input digit_thousands, input updated,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/ssf_digit_encoder.sv =====
// Combinational split of a reading into four decimal digits and their segment bytes.
// Depends on ssf_pkg (constants, reciprocals, segment map, result type).
`default_nettype none

module ssf_digit_encoder (
  input  logic signed [ssf_pkg::ValueWidth-1:0] value_i,
  input  logic                                  row_i,
  output ssf_pkg::ssf_result_t                  result_o
);

  logic                            in_range;
  logic [ssf_pkg::MagWidth-1:0]    mag;
  logic [29:0]                     prod_ten;
  logic [26:0]                     prod_hundred;
  logic [28:0]                     prod_thousand;
  logic [9:0]                      quot_ten;       // value / 10, at most 999
  logic [6:0]                      quot_hundred;   // value / 100, at most 99
  logic [3:0]                      quot_thousand;  // value / 1000, at most 9
  logic [ssf_pkg::MagWidth-1:0]    rem_ones;
  logic [9:0]                      rem_tens;
  logic [6:0]                      rem_hundreds;

  assign in_range = !value_i[ssf_pkg::ValueWidth-1] && (value_i[14:0] <= ssf_pkg::MaxShown);
  assign mag      = value_i[ssf_pkg::MagWidth-1:0];

  // Three independent constant divisions, then remainders by subtraction.
  assign prod_ten      = 30'(mag) * 30'(ssf_pkg::RecipTen);
  assign prod_hundred  = 27'(mag) * 27'(ssf_pkg::RecipHundred);
  assign prod_thousand = 29'(mag) * 29'(ssf_pkg::RecipThousand);

  assign quot_ten      = prod_ten[28:19];
  assign quot_hundred  = prod_hundred[25:19];
  assign quot_thousand = prod_thousand[27:24];

  assign rem_ones     = mag - (14'(quot_ten) * 14'd10);
  assign rem_tens     = quot_ten - (10'(quot_hundred) * 10'd10);
  assign rem_hundreds = quot_hundred - (7'(quot_thousand) * 7'd10);

  always_comb begin
    result_o                 = '0;
    result_o.row_out         = row_i;
    if (in_range) begin
      result_o.updated         = 1'b1;
      result_o.digit_ones      = ssf_pkg::seg_encode(rem_ones[3:0]);
      result_o.digit_tens      = ssf_pkg::seg_encode(rem_tens[3:0]) | ssf_pkg::SegDp;
      // Blank leading digits: a zero quotient means the value sits below that decade.
      result_o.digit_hundreds  = (quot_hundred != '0) ?
                                 ssf_pkg::seg_encode(rem_hundreds[3:0]) : ssf_pkg::SegBlank;
      result_o.digit_thousands = (quot_thousand != '0) ?
                                 ssf_pkg::seg_encode(quot_thousand) : ssf_pkg::SegBlank;
    end
  end

endmodule

`default_nettype wire

// ===== sv/seven_segment_tenths_formatter_unit.sv =====
// Top level of the seven-segment tenths formatter: input register, digit encoder, result register.
// Depends on ssf_pkg, ssf_in_if, ssf_out_if and ssf_digit_encoder.
//
//   channel  | dir | beat contents                                   | handshake
//   ---------+-----+-------------------------------------------------+-------------
//   in_i     | in  | value (signed 16b, tenths), row (1b)            | valid/ready
//   out_o    | out | row_out, four segment bytes (ones first), updated | valid/ready
//
// Path: a beat taken on in_i lands in the input register, passes the digit encoder
//   and is loaded into the result register once that register is free or being taken;
//   it then shows on out_o and is held there until out_o.ready takes it.
// Throughput: one beat per cycle while out_o stays ready, set by the two-stage register
//   pipeline; the encoder does its three constant divisions side by side in one pass.
// Stalls: each stage advances when the stage after it is empty or draining, so a held
//   result does not stop the input register from filling.
// Reset: rst_ni clears both stage valid flags; payload registers are not reset.
`default_nettype none

module seven_segment_tenths_formatter_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssf_in_if.sink        in_i,
  ssf_out_if.source     out_o
);

  // Input register stage.
  logic                                  in_valid_q, in_valid_d;
  logic signed [ssf_pkg::ValueWidth-1:0] in_value_q;
  logic                                  in_row_q;

  // Result register stage.
  logic                                  res_valid_q, res_valid_d;
  ssf_pkg::ssf_result_t                  res_q, res_d;

  logic in_take;
  logic res_load;

  // Load the result register when the input stage holds a beat and the result is free
  // or being taken this cycle.
  assign res_load   = in_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || res_load;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (res_load) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  ssf_digit_encoder u_encoder (
    .value_i  (in_value_q),
    .row_i    (in_row_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload: capture the input on accept and the result on load, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_value_q <= in_i.value;
      in_row_q   <= in_i.row;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.row_out         = res_q.row_out;
  assign out_o.digit_ones      = res_q.digit_ones;
  assign out_o.digit_tens      = res_q.digit_tens;
  assign out_o.digit_hundreds  = res_q.digit_hundreds;
  assign out_o.digit_thousands = res_q.digit_thousands;
  assign out_o.updated         = res_q.updated;

endmodule

`default_nettype wire

// ===== sv/ssf_checker.sv =====
// Port-level checks for the formatter, bound to the top level.
// Depends on assert_macros.svh and ssf_pkg.
`default_nettype none
`include "assert_macros.svh"

module ssf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [ssf_pkg::SegWidth-1:0] digit_ones,
  input wire logic [ssf_pkg::SegWidth-1:0] digit_tens,
  input wire logic [ssf_pkg::SegWidth-1:0] digit_hundreds,
  input wire logic [ssf_pkg::SegWidth-1:0] digit_thousands,
  input wire logic                         updated
);

  // A stalled result must stay offered.
  `SSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // An out-of-range reading carries no segments.
  `SSF_ASSERT(a_reject_blank, !(out_valid && !updated) || ((digit_ones == '0) && (digit_tens == '0) && (digit_hundreds == '0) && (digit_thousands == '0)), "rejected reading has segments lit")

  // A shown reading always lights the decimal point on the second digit.
  `SSF_ASSERT(a_point_lit, !(out_valid && updated) || ((digit_tens & ssf_pkg::SegDp) == ssf_pkg::SegDp), "decimal point missing")

  // Blanking runs from the top: a lit thousands digit needs a lit hundreds digit.
  `SSF_ASSERT(a_blank_order, !(out_valid && updated && (digit_thousands != '0)) || (digit_hundreds != '0), "hundreds blanked under a lit thousands digit")

endmodule

bind seven_segment_tenths_formatter_unit ssf_checker u_ssf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .digit_ones      (out_o.digit_ones),
  .digit_tens      (out_o.digit_tens),
  .digit_hundreds  (out_o.digit_hundreds),
  .digit_thousands (out_o.digit_thousands),
  .updated         (out_o.updated)
);

`default_nettype wire

// ===== bench/tb_seven_segment_tenths_formatter_unit.sv =====
// Self-checking bench for seven_segment_tenths_formatter_unit: readings in, segment bytes out.
// Depends on ssf_pkg, ssf_in_if, ssf_out_if and the unit; predicts every display beat and checks in order.
`timescale 1ns / 100ps
`default_nettype none

module tb_seven_segment_tenths_formatter_unit;

  // Segment glyphs for digits 0..9, digit 0 in the lowest byte.
  localparam logic [79:0] DigitGlyphs = {8'hEB, 8'hEF, 8'hA1, 8'hEE, 8'hEA,
                                         8'h63, 8'hAB, 8'h8F, 8'h21, 8'hED};
  localparam int unsigned DisplayLimit = 9999;
  localparam int unsigned LongHold     = 50;   // cycles the receiver holds off under pressure
  localparam int unsigned DrainCycles  = 8;    // two register stages plus margin
  localparam int unsigned PhaseReadings = 463;

  // Holds the outstanding displays and does the in-order comparison.
  class tenths_display_book;
    ssf_pkg::ssf_result_t pending_displays[$];
    int unsigned mismatch_count;
    int unsigned beats_seen;

    function new();
      mismatch_count = 0;
      beats_seen     = 0;
    endfunction

    function logic [7:0] glyph(int unsigned digit);
      return DigitGlyphs[digit*8 +: 8];
    endfunction

    // Work out the display for one reading.
    function ssf_pkg::ssf_result_t format_tenths(logic signed [15:0] reading, logic row);
      ssf_pkg::ssf_result_t shown;
      int unsigned mag;
      shown = '0;
      shown.row_out = row;
      if (reading < 0 || reading > DisplayLimit) return shown;
      mag = reading;
      shown.digit_ones = glyph(mag % 10);
      shown.digit_tens = glyph((mag / 10) % 10) | ssf_pkg::SegDp;
      shown.digit_hundreds  = (mag >= 100)  ? glyph((mag / 100) % 10)  : ssf_pkg::SegBlank;
      shown.digit_thousands = (mag >= 1000) ? glyph((mag / 1000) % 10) : ssf_pkg::SegBlank;
      shown.updated = 1'b1;
      return shown;
    endfunction

    function void note_reading(logic signed [15:0] reading, logic row);
      pending_displays.push_back(format_tenths(reading, row));
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH at beat %0d: %s", beats_seen, what);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(ssf_pkg::ssf_result_t got);
      ssf_pkg::ssf_result_t want;
      beats_seen++;
      if (pending_displays.size() == 0) begin
        report_mismatch("display beat with no reading outstanding");
        return;
      end
      want = pending_displays.pop_front();
      compare_field("row_out",         got.row_out,         want.row_out);
      compare_field("digit_ones",      got.digit_ones,      want.digit_ones);
      compare_field("digit_tens",      got.digit_tens,      want.digit_tens);
      compare_field("digit_hundreds",  got.digit_hundreds,  want.digit_hundreds);
      compare_field("digit_thousands", got.digit_thousands, want.digit_thousands);
      compare_field("updated",         got.updated,         want.updated);
    endtask

    task close_out();
      if (pending_displays.size() != 0)
        report_mismatch($sformatf("%0d displays never arrived", pending_displays.size()));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  ssf_in_if  in_ch();
  ssf_out_if out_ch();

  seven_segment_tenths_formatter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tenths_display_book book = new();

  // Idle and stall odds, in percent. The sender's odds are read only by the sender process.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  // Bump hold_requests to ask the receiver for one long hold-off.
  int unsigned hold_requests  = 0;

  // Free-running clock, 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_seven_segment_tenths_formatter_unit failed");
    $finish;
  end

  // Offer one reading, idling first at the current odds, and hold it until it is taken.
  // Valid is only lowered on an idle cycle, so a back-to-back beat keeps it high.
  task automatic send_reading(input logic signed [15:0] reading, input logic row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= reading;
    in_ch.row   <= row;
    do @(posedge clk_i); while (!in_ch.ready);
    book.note_reading(reading, row);
  endtask

  // Draw one reading: mostly displayable values of every size, some edges, some raw noise
  // over the whole 16-bit range so that negative and oversized readings keep turning up.
  task automatic send_random_reading();
    logic signed [15:0] edges [12];
    logic signed [15:0] reading;
    int unsigned pick;
    edges = '{16'sd0, 16'sd9, 16'sd10, 16'sd99, 16'sd100, 16'sd999, 16'sd1000,
              16'sd9999, 16'sd10000, -16'sd1, -16'sd32768, 16'sd32767};
    pick = $urandom_range(99);
    if (pick < 10)      reading = 16'($urandom_range(9));
    else if (pick < 20) reading = 16'($urandom_range(99));
    else if (pick < 30) reading = 16'($urandom_range(999));
    else if (pick < 68) reading = 16'($urandom_range(DisplayLimit));
    else if (pick < 76) reading = edges[$urandom_range(11)];
    else                reading = 16'($urandom());
    send_reading(reading, 1'($urandom_range(1)));
  endtask

  // Receiver: check every beat taken, then pick ready for the next edge. A long hold-off
  // is counted down here so the pipeline fills and the input side has to stall.
  initial begin
    ssf_pkg::ssf_result_t got;
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.row_out         = out_ch.row_out;
        got.digit_ones      = out_ch.digit_ones;
        got.digit_tens      = out_ch.digit_tens;
        got.digit_hundreds  = out_ch.digit_hundreds;
        got.digit_thousands = out_ch.digit_thousands;
        got.updated         = out_ch.updated;
        book.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LongHold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed readings, then random phases with varied idling.
  initial begin
    int unsigned spins;
    rst_ni      <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.row   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: blanking edges, the single-digit case, both out-of-range sides,
    // every digit in at least one position, both rows.
    send_reading(16'sd0, 1'b0);
    send_reading(16'sd9, 1'b1);
    send_reading(16'sd10, 1'b0);
    send_reading(16'sd99, 1'b1);
    send_reading(16'sd100, 1'b0);
    send_reading(16'sd999, 1'b1);
    send_reading(16'sd1000, 1'b0);
    send_reading(16'sd9999, 1'b1);
    send_reading(16'sd10000, 1'b0);
    send_reading(-16'sd1, 1'b1);
    send_reading(-16'sd32768, 1'b0);
    send_reading(16'sd32767, 1'b1);
    send_reading(16'sd1234, 1'b0);
    send_reading(16'sd5678, 1'b1);
    send_reading(16'sd9012, 1'b0);
    send_reading(16'sd3456, 1'b1);
    send_reading(16'sd7890, 1'b0);
    send_reading(16'sd5, 1'b1);
    send_reading(16'sd57, 1'b0);
    send_reading(16'sd420, 1'b1);

    // Phase: no idling on either side.
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    repeat (PhaseReadings) send_random_reading();

    // Pressure: hold the receiver off for a long stretch while readings keep coming.
    hold_requests <= hold_requests + 1;
    repeat (60) send_random_reading();

    // Phase: sender idles often.
    src_idle_pct = 58;
    sink_stall_pct <= 0;
    repeat (PhaseReadings) send_random_reading();

    // Phase: receiver stalls often.
    src_idle_pct = 0;
    sink_stall_pct <= 58;
    repeat (PhaseReadings) send_random_reading();

    // Phase: both sides idle now and then.
    src_idle_pct = 13;
    sink_stall_pct <= 13;
    repeat (PhaseReadings) send_random_reading();

    in_ch.valid <= 1'b0;

    // Drain: wait for every outstanding display, then a few more cycles for strays.
    spins = 0;
    while (book.pending_displays.size() != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    book.close_out();

    if (book.mismatch_count == 0) begin
      $display("tb_seven_segment_tenths_formatter_unit passed");
    end else begin
      $display("tb_seven_segment_tenths_formatter_unit failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/ssf_pkg.sv
sv/ssf_in_if.sv
sv/ssf_out_if.sv
sv/ssf_digit_encoder.sv
sv/seven_segment_tenths_formatter_unit.sv
sv/ssf_checker.sv
bench/tb_seven_segment_tenths_formatter_unit.sv
